/* src/spdbsd_pkg.sv */
// shared constants, types and the checksum step for the short packet deframer
// no dependencies; the files that use it refer to this package by scoped names
package spdbsd_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = 5;
    localparam int ADDR_W      = IDX_W + 1;
    localparam int RAM_DEPTH   = 2 ** ADDR_W;

    localparam logic [7:0] LEN_MASK = 8'(MAX_PAYLOAD - 1);

    // one finished packet handed from the front to the back
    typedef struct packed {
        logic             fail;
        logic [LEN_W-1:0] len;
        logic             bank;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SHOW
    } back_state_t;

    // bsd checksum: rotate right by one, then add
    function automatic logic [7:0] sum_step(input logic [7:0] sum, input logic [7:0] b);
        return {sum[0], sum[7:1]} + b;
    endfunction

endpackage

/* src/spdbsd_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module spdbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/spdbsd_front.sv */
// front part: parses header, payload and checksum words, writes the payload store
// depends on spdbsd_pkg
module spdbsd_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [7:0]                   rx_byte,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         q_full,
    output logic                         wr_en,
    output logic [spdbsd_pkg::ADDR_W-1:0] wr_addr,
    output logic [7:0]                   wr_data,
    output logic                         push,
    output spdbsd_pkg::cmd_t             cmd
);

    logic                         receiving_reg, receiving_next;
    logic [spdbsd_pkg::LEN_W-1:0] len_reg, len_next;
    logic [spdbsd_pkg::LEN_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                   sum_reg, sum_next;
    logic                         bank_reg, bank_next;

    logic accept;
    logic is_ck;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;
    assign is_ck    = receiving_reg && (cnt_reg == len_reg);

    assign wr_en    = accept & receiving_reg & ~is_ck;
    assign wr_addr  = {bank_reg, cnt_reg[spdbsd_pkg::IDX_W-1:0]};
    assign wr_data  = rx_byte;
    assign push     = accept & is_ck;
    assign cmd.fail = (rx_byte != sum_reg);
    assign cmd.len  = len_reg;
    assign cmd.bank = bank_reg;

    always_comb
    begin
        receiving_next = receiving_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        bank_next      = bank_reg;
        if (accept)
        begin
            if (!receiving_reg)
            begin
                receiving_next = 1'b1;
                len_next = spdbsd_pkg::LEN_W'(rx_byte & spdbsd_pkg::LEN_MASK)
                           + spdbsd_pkg::LEN_W'(1);
                cnt_next = '0;
                sum_next = spdbsd_pkg::sum_step(8'd0, rx_byte);
            end
            else if (is_ck)
            begin
                receiving_next = 1'b0;
                // a good packet keeps its bank until the back has drained it
                if (rx_byte == sum_reg)
                begin
                    bank_next = ~bank_reg;
                end
            end
            else
            begin
                cnt_next = cnt_reg + spdbsd_pkg::LEN_W'(1);
                sum_next = spdbsd_pkg::sum_step(sum_reg, rx_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            bank_reg      <= 1'b0;
        end
        else
        begin
            receiving_reg <= receiving_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            bank_reg      <= bank_next;
        end
    end

endmodule

/* src/spdbsd_cmd_queue.sv */
// two-entry queue of finished packets between front and back
// depends on spdbsd_pkg
module spdbsd_cmd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  spdbsd_pkg::cmd_t push_cmd,
    input  logic             pop,
    output spdbsd_pkg::cmd_t head,
    output logic             not_empty,
    output logic             full
);

    spdbsd_pkg::cmd_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/spdbsd_back.sv */
// back part: drains one queued packet at a time into the output register
// depends on spdbsd_pkg
module spdbsd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spdbsd_pkg::cmd_t              head,
    input  logic                          q_valid,
    output logic                          pop,
    output logic                          rd_en,
    output logic [spdbsd_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]                    rd_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic [7:0]                    payload_byte,
    output logic [spdbsd_pkg::LEN_W-1:0]  payload_length,
    output logic                          last
);

    spdbsd_pkg::back_state_t      state_reg, state_next;
    logic [spdbsd_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                         status_reg, status_next;
    logic [7:0]                   byte_reg, byte_next;
    logic [spdbsd_pkg::LEN_W-1:0] len_reg, len_next;
    logic                         last_reg, last_next;

    assign out_valid      = (state_reg == spdbsd_pkg::B_SHOW);
    assign status         = status_reg;
    assign payload_byte   = byte_reg;
    assign payload_length = len_reg;
    assign last           = last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spdbsd_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = head.fail ? spdbsd_pkg::B_SHOW : spdbsd_pkg::B_READ;
                end
            end
            spdbsd_pkg::B_READ:
            begin
                state_next = spdbsd_pkg::B_SHOW;
            end
            spdbsd_pkg::B_SHOW:
            begin
                if (!out_stall)
                begin
                    state_next = last_reg ? spdbsd_pkg::B_IDLE : spdbsd_pkg::B_READ;
                end
            end
            default:
            begin
                state_next = spdbsd_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = {head.bank, idx_reg};
        idx_next    = idx_reg;
        status_next = status_reg;
        byte_next   = byte_reg;
        len_next    = len_reg;
        last_next   = last_reg;
        case (state_reg)
            spdbsd_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    idx_next = '0;
                    if (head.fail)
                    begin
                        status_next = 1'b1;
                        byte_next   = 8'd0;
                        len_next    = head.len;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = {head.bank, {spdbsd_pkg::IDX_W{1'b0}}};
                    end
                end
            end
            spdbsd_pkg::B_READ:
            begin
                status_next = 1'b0;
                byte_next   = rd_data;
                len_next    = head.len;
                last_next   = ((spdbsd_pkg::LEN_W'(idx_reg) + spdbsd_pkg::LEN_W'(1))
                               == head.len);
            end
            spdbsd_pkg::B_SHOW:
            begin
                if (!out_stall)
                begin
                    if (last_reg)
                    begin
                        pop = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + spdbsd_pkg::IDX_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = {head.bank, idx_reg + spdbsd_pkg::IDX_W'(1)};
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spdbsd_pkg::B_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        byte_reg   <= byte_next;
        len_reg    <= len_next;
        last_reg   <= last_next;
    end

endmodule

/* src/short_packet_deframer_bsd_checksum_unit.sv */
// top level of the length-prefixed packet deframer with 8-bit bsd checksum
// depends on spdbsd_pkg, spdbsd_front, spdbsd_cmd_queue, spdbsd_back, spdbsd_ram

// Receive words are taken one per cycle unless in_stall is high: a header (low
// bits give payload length minus one), the payload, then the checksum. A good
// packet is delivered as payload_length result words with last on the final
// one; a bad checksum gives a single result word with status set and last set.
// The payload store holds two banks, so the next packet can arrive while the
// previous one is still being delivered; in_stall rises only while two finished
// packets are waiting or in delivery. Each word comes from the registered ram
// read via the output register; the next is read once the current one is taken.
module short_packet_deframer_bsd_checksum_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [7:0]                   rx_byte,
    input  logic                         in_valid,
    output logic                         in_stall,
    output logic                         status,
    output logic [7:0]                   payload_byte,
    output logic [spdbsd_pkg::LEN_W-1:0] payload_length,
    output logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall
);

    logic                          q_full;
    logic                          q_valid;
    logic                          push;
    logic                          pop;
    spdbsd_pkg::cmd_t              push_cmd;
    spdbsd_pkg::cmd_t              head;
    logic                          wr_en;
    logic [spdbsd_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                    wr_data;
    logic                          rd_en;
    logic [spdbsd_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                    rd_data;

    spdbsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_full   (q_full),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .push     (push),
        .cmd      (push_cmd)
    );

    spdbsd_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (q_valid),
        .full      (q_full)
    );

    spdbsd_ram #(
        .WIDTH (8),
        .DEPTH (spdbsd_pkg::RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    spdbsd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_valid        (q_valid),
        .pop            (pop),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .payload_byte   (payload_byte),
        .payload_length (payload_length),
        .last           (last)
    );

endmodule

/* dv/spdbsd_checker.sv */
`timescale 1ns / 1ps
// checker for the short packet deframer: watches both channels, predicts the delivered
// words from the received ones and compares them; depends on spdbsd_pkg only

module spdbsd_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [7:0]                   rx_byte,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         status,
    input  logic [7:0]                   payload_byte,
    input  logic [spdbsd_pkg::LEN_W-1:0] payload_length,
    input  logic                         last,
    input  logic                         out_valid,
    input  logic                         out_stall,
    output int                           errors,
    output int                           outstanding
);

    localparam int LW = spdbsd_pkg::LEN_W;

    typedef struct packed {
        logic          status;
        logic [7:0]    data;
        logic [LW-1:0] len;
        logic          last;
    } delivery_t;

    delivery_t     deliveries[$];
    logic          in_frame;
    logic [LW-1:0] plen;
    logic [LW-1:0] got;
    logic [7:0]    csum;
    logic [7:0]    held [spdbsd_pkg::MAX_PAYLOAD];

    function automatic logic [7:0] rotate_add(input logic [7:0] s, input logic [7:0] b);
        return ((s >> 1) | (s << 7)) + b;
    endfunction

    // header, payload or checksum word, by position in the packet
    task take_word(input logic [7:0] b);
        int k;
        if (!in_frame)
        begin
            in_frame = 1'b1;
            plen     = LW'(b & spdbsd_pkg::LEN_MASK) + LW'(1);
            got      = '0;
            csum     = rotate_add(8'h00, b);
        end
        else if (got == plen)
        begin
            in_frame = 1'b0;
            if (b != csum)
                deliveries.push_back('{1'b1, 8'h00, plen, 1'b1});
            else
                for (k = 0; k < int'(plen); k++)
                    deliveries.push_back('{1'b0, held[k[spdbsd_pkg::IDX_W-1:0]], plen,
                                           k == int'(plen) - 1});
        end
        else
        begin
            held[got[spdbsd_pkg::IDX_W-1:0]] = b;
            csum      = rotate_add(csum, b);
            got       = got + LW'(1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        delivery_t want;
        if (!rst_n)
        begin
            deliveries.delete();
            in_frame    = 1'b0;
            plen        = '0;
            got         = '0;
            csum        = 8'h00;
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                take_word(rx_byte);
            if (out_valid && !out_stall)
            begin
                if (deliveries.size() == 0)
                begin
                    $error("result word with nothing expected: status %0d byte %02h len %0d",
                           status, payload_byte, payload_length);
                    errors = errors + 1;
                end
                else
                begin
                    want = deliveries.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors = errors + 1;
                    end
                    if (payload_byte !== want.data)
                    begin
                        $error("payload_byte: expected %02h, got %02h", want.data, payload_byte);
                        errors = errors + 1;
                    end
                    if (payload_length !== want.len)
                    begin
                        $error("payload_length: expected %0d, got %0d", want.len, payload_length);
                        errors = errors + 1;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        errors = errors + 1;
                    end
                end
            end
            outstanding = deliveries.size();
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// top of the deframer testbench: clock, reset, packet stimulus, receiver stalls and verdict
// depends on spdbsd_pkg, spdbsd_checker and the short_packet_deframer_bsd_checksum_unit rtl

module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int END_DRAIN      = 40;
    localparam int WORDS_WANTED   = 96;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic [7:0]                   rx_byte   = 8'h00;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic                         status;
    logic [7:0]                   payload_byte;
    logic [spdbsd_pkg::LEN_W-1:0] payload_length;
    logic                         last;
    logic                         out_valid;
    logic                         out_stall = 1'b0;

    int       errors;
    int       outstanding;
    int       hold_left   = 0;
    int       stall_run   = 0;
    int       quiet_count = 0;
    bit       calm        = 1'b0;
    logic [7:0] body [spdbsd_pkg::MAX_PAYLOAD];

    always #5 clk = ~clk;

    short_packet_deframer_bsd_checksum_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .status         (status),
        .payload_byte   (payload_byte),
        .payload_length (payload_length),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall)
    );

    spdbsd_checker u_watch (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .status         (status),
        .payload_byte   (payload_byte),
        .payload_length (payload_length),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .errors         (errors),
        .outstanding    (outstanding)
    );

    // ends the run if no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_count <= 0;
        else if (quiet_count + 1 >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
            quiet_count <= quiet_count + 1;
    end

    // receiver: long hold-off on request, no stalls while calm, otherwise random stalls of random length
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left = hold_left - 1;
        end
        else if (calm)
            out_stall = 1'b0;
        else if (stall_run > 0)
        begin
            out_stall = 1'b1;
            stall_run = stall_run - 1;
        end
        else if ($urandom_range(0, 99) < 60)
            out_stall = 1'b0;
        else
        begin
            out_stall = 1'b1;
            stall_run = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                     : $urandom_range(4, 25);
        end
    end

    function automatic logic [7:0] rotate_add(input logic [7:0] s, input logic [7:0] b);
        return ((s >> 1) | (s << 7)) + b;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 24);
    endfunction

    // offers one word at the falling edge and holds it until it is taken
    task automatic offer_word(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_byte  = b;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // header, payload from body[], then the checksum, spoiled if asked
    task automatic send_frame(input logic [7:0] hdr, input bit spoil);
        int         n;
        int         k;
        logic [7:0] s;
        n = int'(hdr & spdbsd_pkg::LEN_MASK) + 1;
        s = rotate_add(8'h00, hdr);
        offer_word(hdr);
        for (k = 0; k < n; k++)
        begin
            s = rotate_add(s, body[k[spdbsd_pkg::IDX_W-1:0]]);
            offer_word(body[k[spdbsd_pkg::IDX_W-1:0]]);
        end
        if (spoil)
            s = s ^ 8'($urandom_range(1, 255));
        offer_word(s);
    endtask

    initial
    begin : stimulus
        int         k;
        int         pkt;
        int         plen;
        int         r;
        int         words_sent;
        logic [7:0] hdr;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one-byte payload with version and type bits all set
        body[0] = 8'hFF;
        send_frame(8'hF0, 1'b0);
        // largest payload, all header bits set
        for (k = 0; k < spdbsd_pkg::MAX_PAYLOAD; k++)
            body[k[spdbsd_pkg::IDX_W-1:0]] = 8'(k * 8'h11);
        body[spdbsd_pkg::MAX_PAYLOAD-1] = 8'hFF;
        send_frame(8'hFF, 1'b0);
        // bad checksum on the smallest packet
        body[0] = 8'h00;
        send_frame(8'h00, 1'b1);

        // sender pauses until every delivery is in
        @(negedge clk);
        in_valid = 1'b0;
        wait (outstanding == 0);

        words_sent = 0;
        pkt        = 0;
        while (words_sent < WORDS_WANTED)
        begin
            calm = ((pkt / 4) % 3 == 2);
            // receiver holds off while packets keep coming, so the input stalls
            if (pkt == 6)
                hold_left = HOLD_CYCLES;
            r    = $urandom_range(0, 99);
            plen = (r < 70) ? $urandom_range(1, 4)
                 : (r < 90) ? $urandom_range(5, 10)
                 :            $urandom_range(11, spdbsd_pkg::MAX_PAYLOAD);
            for (k = 0; k < plen; k++)
                body[k[spdbsd_pkg::IDX_W-1:0]] = 8'($urandom);
            hdr = (8'($urandom) & ~spdbsd_pkg::LEN_MASK) | 8'(plen - 1);
            send_frame(hdr, $urandom_range(0, 99) < 20);
            words_sent = words_sent + plen + 2;
            pkt        = pkt + 1;
        end

        @(negedge clk);
        in_valid = 1'b0;
        calm     = 1'b0;
        wait (outstanding == 0);
        repeat (END_DRAIN) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
